@@ rtl/thrm_pkg.sv @@
// ----------------------------------------------------------------------------
// thrm_pkg
// Shared types, operation codes and defaults for the tagged history ring
// matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package thrm_pkg;

   // Default geometry
   localparam int THRM_DEPTH    = 128;
   localparam int THRM_TAG_BITS = 64;

   // Operation codes
   localparam logic [1:0] OP_RECORD   = 2'd0;
   localparam logic [1:0] OP_ANNOTATE = 2'd1;
   localparam logic [1:0] OP_TAKE     = 2'd2;

   // Request payload
   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] event_tag;
      logic [15:0] risk_level;
      logic [15:0] pose_level;
      logic [15:0] eeg_level;
      logic [15:0] burst_level;
      logic [7:0]  classifier_result;
   } req_type;

   // Response payload
   typedef struct packed {
      logic        hit;
      logic [63:0] tag_out;
      logic [15:0] risk_out;
      logic [15:0] pose_out;
      logic [15:0] eeg_out;
      logic [15:0] burst_out;
      logic [7:0]  result_out;
   } rsp_type;

   // Commands to the ring pointer unit
   typedef struct packed {
      logic advance;   // record written, move write pointer
      logic start;     // begin a newest-first walk
      logic step;      // walk one entry further back
   } ptr_cmd_type;

   // Status from the ring pointer unit
   typedef struct packed {
      logic empty;     // nothing recorded yet
      logic rd_last;   // current walk slot is the oldest filled entry
   } ptr_stat_type;

endpackage

`default_nettype wire

@@ rtl/tagged_history_ring_matcher_core.sv @@
// ----------------------------------------------------------------------------
// tagged_history_ring_matcher_core
// History ring of tagged samples with newest-first tag match and take.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one operation per transfer: record a sample over the
//   oldest slot, annotate the newest entry with a matching nonzero tag, or
//   take the newest annotated entry. Every request yields exactly one rsp
//   transfer.
//   Record passes through S_OUT and then loads the output register.
//   Annotate and take walk the filled entries newest first, one RAM read per
//   cycle through the registered RAM read port; a hit ends the walk early.
//   The single RAM read port sets the pace of the walk. One request is
//   worked on at a time and req_ready returns as the output register loads.
//   req_ready is also high while a finished response still waits in the
//   output register.
//   If the receiver stalls, the next finished result holds until the output
//   register frees, and req_ready stays low meanwhile. Reset empties the ring
//   at once (fill count and pointers cleared); no clearing pass runs, since
//   only filled entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_history_ring_matcher_core
   import thrm_pkg::*;
#(
   parameter int DEPTH    = THRM_DEPTH,
   parameter int TAG_BITS = THRM_TAG_BITS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int AW       = $clog2(DEPTH);
   localparam int SC_LO    = TAG_BITS;
   localparam int RES_LO   = TAG_BITS + 64;
   localparam int PEND_BIT = TAG_BITS + 72;
   localparam int W        = TAG_BITS + 73;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_OUT  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [7:0]          cls_ff, cls_in;
   logic                iss_on_ff, iss_on_in;
   logic                d_vld_ff, d_vld_in;
   logic                d_last_ff, d_last_in;
   logic [AW-1:0]       d_slot_ff, d_slot_in;
   rsp_type             res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   ptr_cmd_type         pcmd;
   ptr_stat_type        pstat;
   logic [AW-1:0]       wr_slot, rd_slot;

   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr;
   logic [W-1:0]        wr_data, rd_data;

   logic                req_xfer;
   logic [TAG_BITS-1:0] req_tag;
   logic                match;

   thrm_ring_ptr #(.DEPTH(DEPTH)) u_ptr (
      .clock   (clock),
      .reset   (reset),
      .cmd     (pcmd),
      .wr_slot (wr_slot),
      .rd_slot (rd_slot),
      .stat    (pstat)
   );

   thrm_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_slot),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign req_tag   = req_data.event_tag[TAG_BITS-1:0];

   // Match test on the entry read in the previous cycle
   assign match = (op_ff == OP_ANNOTATE) ? (rd_data[TAG_BITS-1:0] == tag_ff)
                                         : rd_data[PEND_BIT];

   // Sequencer: accept, walk the ring, write back, hand over the result
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      tag_in       = tag_ff;
      cls_in       = cls_ff;
      iss_on_in    = iss_on_ff;
      d_vld_in     = 1'b0;
      d_last_in    = d_last_ff;
      d_slot_in    = d_slot_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pcmd         = '0;
      wr_en        = 1'b0;
      wr_addr      = wr_slot;
      wr_data      = {1'b0, 8'd0, req_data.burst_level, req_data.eeg_level,
                      req_data.pose_level, req_data.risk_level, req_tag};
      rd_en        = 1'b0;

      // Drop the response once transferred
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               op_in  = req_data.operation;
               tag_in = req_tag;
               cls_in = req_data.classifier_result;
               res_in = '0;
               unique case (req_data.operation)
                  OP_RECORD: begin
                     wr_en        = 1'b1;
                     pcmd.advance = 1'b1;
                     state_in     = S_OUT;
                  end
                  OP_ANNOTATE: begin
                     if ((req_tag != '0) && !pstat.empty) begin
                        pcmd.start = 1'b1;
                        iss_on_in  = 1'b1;
                        state_in   = S_SCAN;
                     end else begin
                        state_in = S_OUT;
                     end
                  end
                  OP_TAKE: begin
                     if (!pstat.empty) begin
                        pcmd.start = 1'b1;
                        iss_on_in  = 1'b1;
                        state_in   = S_SCAN;
                     end else begin
                        state_in = S_OUT;
                     end
                  end
                  default: begin
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // Issue the next read of the walk
            if (iss_on_ff) begin
               rd_en     = 1'b1;
               pcmd.step = 1'b1;
               d_vld_in  = 1'b1;
               d_last_in = pstat.rd_last;
               d_slot_in = rd_slot;
               iss_on_in = !pstat.rd_last;
            end
            // Evaluate the entry that came back
            if (d_vld_ff && match) begin
               wr_en   = 1'b1;
               wr_addr = d_slot_ff;
               wr_data = rd_data;
               res_in  = '0;
               res_in.hit = 1'b1;
               if (op_ff == OP_ANNOTATE) begin
                  wr_data[RES_LO +: 8] = cls_ff;
                  wr_data[PEND_BIT]    = 1'b1;
               end else begin
                  wr_data[PEND_BIT]  = 1'b0;
                  res_in.tag_out     = 64'(rd_data[TAG_BITS-1:0]);
                  res_in.risk_out    = rd_data[SC_LO +: 16];
                  res_in.pose_out    = rd_data[SC_LO + 16 +: 16];
                  res_in.eeg_out     = rd_data[SC_LO + 32 +: 16];
                  res_in.burst_out   = rd_data[SC_LO + 48 +: 16];
                  res_in.result_out  = rd_data[RES_LO +: 8];
               end
               iss_on_in = 1'b0;
               d_vld_in  = 1'b0;
               state_in  = S_OUT;
            end else if (d_vld_ff && d_last_ff) begin
               res_in    = '0;
               iss_on_in = 1'b0;
               d_vld_in  = 1'b0;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            // Load the output register when it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iss_on_ff    <= 1'b0;
         d_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_on_ff    <= iss_on_in;
         d_vld_ff     <= d_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      tag_ff      <= tag_in;
      cls_ff      <= cls_in;
      d_last_ff   <= d_last_in;
      d_slot_ff   <= d_slot_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ rtl/thrm_ram.sv @@
// ----------------------------------------------------------------------------
// thrm_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module thrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/thrm_ring_ptr.sv @@
// ----------------------------------------------------------------------------
// thrm_ring_ptr
// Write pointer, saturating fill count and newest-first walk address
// generator for the history ring.
// ----------------------------------------------------------------------------
`default_nettype none

module thrm_ring_ptr
   import thrm_pkg::*;
#(
   parameter int DEPTH = THRM_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ptr_cmd_type              cmd,
   output logic      [$clog2(DEPTH)-1:0] wr_slot,
   output logic      [$clog2(DEPTH)-1:0] rd_slot,
   output ptr_stat_type                  stat
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] rp_ff, rp_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] left_ff, left_in;

   // Slot one step back, wrapping at the bottom
   function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] s);
      prev_slot = (s == '0) ? AW'(DEPTH - 1) : s - AW'(1);
   endfunction

   // Advance write side on record, walk read side on request
   always_comb begin
      wp_in   = wp_ff;
      fill_in = fill_ff;
      rp_in   = rp_ff;
      left_in = left_ff;
      if (cmd.advance) begin
         wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
         if (fill_ff != CW'(DEPTH)) begin
            fill_in = fill_ff + CW'(1);
         end
      end
      if (cmd.start) begin
         rp_in   = prev_slot(wp_ff);
         left_in = fill_ff;
      end else if (cmd.step) begin
         rp_in   = prev_slot(rp_ff);
         left_in = left_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
         rp_ff   <= '0;
         left_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
         rp_ff   <= rp_in;
         left_ff <= left_in;
      end
   end

   assign wr_slot      = wp_ff;
   assign rd_slot      = rp_ff;
   assign stat.empty   = (fill_ff == '0);
   assign stat.rd_last = (left_ff == CW'(1));

endmodule

`default_nettype wire

@@ rtl/thrm_checker.sv @@
// ----------------------------------------------------------------------------
// thrm_checker
// Port-level checks for the tagged history ring matcher, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module thrm_checker
   import thrm_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // No response straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // One request at a time: busy after each request transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous one in flight");

   // A miss carries all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |->
         (rsp_data.tag_out == '0) && (rsp_data.risk_out == '0) &&
         (rsp_data.pose_out == '0) && (rsp_data.eeg_out == '0) &&
         (rsp_data.burst_out == '0) && (rsp_data.result_out == '0))
      else $error("miss response with nonzero fields");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind tagged_history_ring_matcher_core thrm_checker u_thrm_checker (.*);

`default_nettype wire
